[rtl/dad_pkg.sv]
// Package for the date adder: sequencer states, calendar limits and month lengths.
// Used by date_add_days and its checker; depends on nothing else.
package dad_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned OffW   = 13;
  // Working day count: day_in plus offset spans -4096..4126
  localparam int unsigned DaccW  = 14;

  localparam logic [YearW-1:0]  MinYear   = 14'd1;
  localparam logic [YearW-1:0]  MaxYear   = 14'd9999;
  localparam logic [YearW-1:0]  LeapCycle = 14'd400;
  localparam logic [8:0]        LastRem   = 9'd399;
  localparam logic [MonthW-1:0] Jan       = 4'd1;
  localparam logic [MonthW-1:0] Feb       = 4'd2;
  localparam logic [MonthW-1:0] Dec       = 4'd12;
  localparam logic [DayW-1:0]   LastDay   = 5'd31;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_FWD,
    ST_BWD,
    ST_DONE
  } dad_state_t;

  // Days in month m; leap selects 29 for February
  function automatic logic [DayW-1:0] month_len(input logic leap, input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

[rtl/date_add_days.sv]
// Sequencing: ST_REDUCE takes the year mod 400, then ST_FWD and ST_BWD cross months one at
// a time; the single day adder handles one month a cycle.
// Throughput: one request at a time; busy stays high from acceptance until the result strobe.
// The result is shown for one cycle on out_valid; the receiver cannot stall.
// Reset (rst_n low, synchronous) returns the sequencer to idle with busy and out_valid low.
// Gregorian date plus signed day offset, normalized one month per cycle.
// Depends on dad_pkg.
module date_add_days (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [dad_pkg::YearW-1:0]     in_year_in,
  input  logic [dad_pkg::MonthW-1:0]    in_month_in,
  input  logic [dad_pkg::DayW-1:0]      in_day_in,
  input  logic signed [dad_pkg::OffW-1:0] in_day_offset,
  output logic                          out_valid,
  output logic [dad_pkg::YearW-1:0]     out_year_out,
  output logic [dad_pkg::MonthW-1:0]    out_month_out,
  output logic [dad_pkg::DayW-1:0]      out_day_out,
  output logic                          out_range_error
);
  import dad_pkg::*;

  dad_state_t state_r, state_nxt;

  logic [YearW-1:0]        year_r, year_nxt;
  logic [MonthW-1:0]       month_r, month_nxt;
  logic signed [DaccW-1:0] day_r, day_nxt;
  logic [YearW-1:0]        rem_r, rem_nxt;   // year mod 400 after reduction
  logic                    err_r, err_nxt;

  logic                    accept;
  logic [YearW-1:0]        year_clamp;
  logic [MonthW-1:0]       month_clamp;
  logic signed [DaccW-1:0] day_start;
  logic                    cent, leap;
  logic [MonthW-1:0]       month_prev;
  logic [DayW-1:0]         len_cur, len_prev;
  logic                    fwd_step, bwd_step;
  logic signed [DaccW-1:0] add_b, day_sum;
  logic [8:0]              rem9;

  assign accept = start && !busy;

  // Input clamping and initial day count
  always_comb begin
    if (in_year_in < MinYear)      year_clamp = MinYear;
    else if (in_year_in > MaxYear) year_clamp = MaxYear;
    else                           year_clamp = in_year_in;
    if (in_month_in < Jan)         month_clamp = Jan;
    else if (in_month_in > Dec)    month_clamp = Dec;
    else                           month_clamp = in_month_in;
    day_start = $signed({{(DaccW-DayW){1'b0}}, in_day_in})
              + $signed({{(DaccW-OffW){in_day_offset[OffW-1]}}, in_day_offset});
  end

  // Leap test from the tracked year mod 400
  assign rem9 = rem_r[8:0];
  assign cent = (rem9 == 9'd0) || (rem9 == 9'd100) || (rem9 == 9'd200) || (rem9 == 9'd300);
  assign leap = ((year_r[1:0] == 2'b00) && !cent) || (rem9 == 9'd0);

  // Month lengths: current month going forward, previous month going back.
  // Stepping back into February never changes the year, so one leap bit serves.
  assign month_prev = (month_r == Jan) ? Dec : month_r - 4'd1;
  assign len_cur    = month_len(leap, month_r);
  assign len_prev   = month_len(leap, month_prev);

  assign fwd_step = day_r > $signed({{(DaccW-DayW){1'b0}}, len_cur});
  assign bwd_step = day_r < $signed(14'sd1);

  // Shared day adder: subtract the month going forward, add it going back
  always_comb begin
    if (state_r == ST_FWD) add_b = -$signed({{(DaccW-DayW){1'b0}}, len_cur});
    else                   add_b =  $signed({{(DaccW-DayW){1'b0}}, len_prev});
    day_sum = day_r + add_b;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_REDUCE;
      ST_REDUCE: if (rem_r < LeapCycle) state_nxt = ST_FWD;
      ST_FWD: begin
        if (!fwd_step) state_nxt = ST_BWD;
        else if (month_r == Dec && year_r == MaxYear) state_nxt = ST_DONE;
      end
      ST_BWD: if (!bwd_step) state_nxt = ST_DONE;
      ST_DONE:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath updates
  always_comb begin
    year_nxt  = year_r;
    month_nxt = month_r;
    day_nxt   = day_r;
    rem_nxt   = rem_r;
    err_nxt   = err_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          year_nxt  = year_clamp;
          month_nxt = month_clamp;
          day_nxt   = day_start;
          rem_nxt   = year_clamp;
          err_nxt   = 1'b0;
        end
      end
      ST_REDUCE: begin
        if (rem_r >= LeapCycle) rem_nxt = rem_r - LeapCycle;
      end
      ST_FWD: begin
        if (fwd_step) begin
          day_nxt = day_sum;
          if (month_r == Dec) begin
            if (year_r == MaxYear) begin
              // ran past the last year: saturate
              err_nxt   = 1'b1;
              month_nxt = Dec;
              day_nxt   = $signed({{(DaccW-DayW){1'b0}}, LastDay});
            end else begin
              month_nxt = Jan;
              year_nxt  = year_r + 14'd1;
              rem_nxt   = (rem9 == LastRem) ? '0 : rem_r + 14'd1;
            end
          end else begin
            month_nxt = month_r + 4'd1;
          end
        end
      end
      ST_BWD: begin
        if (bwd_step) begin
          if (month_r == Jan && year_r == MinYear) begin
            // ran before the first year: saturate
            err_nxt   = 1'b1;
            month_nxt = Jan;
            day_nxt   = 14'sd1;
          end else begin
            month_nxt = month_prev;
            day_nxt   = day_sum;
            if (month_r == Jan) begin
              year_nxt = year_r - 14'd1;
              rem_nxt  = (rem9 == 9'd0) ? {5'd0, LastRem} : rem_r - 14'd1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Outputs
  always_comb begin
    busy            = (state_r != ST_IDLE);
    out_valid       = (state_r == ST_DONE);
    out_year_out    = year_r;
    out_month_out   = month_r;
    out_day_out     = day_r[DayW-1:0];
    out_range_error = err_r;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    year_r  <= year_nxt;
    month_r <= month_nxt;
    day_r   <= day_nxt;
    rem_r   <= rem_nxt;
    err_r   <= err_nxt;
  end

endmodule

[rtl/date_add_days_checker.sv]
// Port-level checks for date_add_days, attached by the bind at the end of this file.
// Depends on dad_pkg and date_add_days.
module date_add_days_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            out_valid,
  input logic [dad_pkg::YearW-1:0]       out_year_out,
  input logic [dad_pkg::MonthW-1:0]      out_month_out,
  input logic [dad_pkg::DayW-1:0]        out_day_out,
  input logic                            out_range_error
);
  import dad_pkg::*;

  // An accepted request keeps the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("request accepted but busy not raised");

  // Result strobe only while a request is in flight
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result strobe while idle");

  // One strobe per request: block frees up right after it
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy) else $error("result strobe repeated");

  // Result date within calendar limits
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_year_out >= MinYear && out_year_out <= MaxYear &&
                  out_month_out >= Jan && out_month_out <= Dec &&
                  out_day_out >= 5'd1) else $error("result date out of range");

  // A saturated result is one of the two limit dates
  a_saturate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |->
      (out_year_out == MaxYear && out_month_out == Dec && out_day_out == LastDay) ||
      (out_year_out == MinYear && out_month_out == Jan && out_day_out == 5'd1))
    else $error("saturated result is not a limit date");

endmodule

bind date_add_days date_add_days_checker u_date_add_days_checker (.*);
